// ===== sv/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// shared types, constants and helpers of the radix digit emitter
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_CYCLES    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int DVD_BITS      = DIV_CYCLES * BITS_PER_STEP;
    localparam int STEP_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int STORE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(STORE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int RADIX_W       = 5;
    localparam int CHAR_W        = 7;
    localparam int COUNT_W       = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_UPPER = 1'b1;

    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
    } rde_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  digit_char;
        logic               last;
        logic [COUNT_W-1:0] running_count;
    } rde_out_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        logic next_digit;
        logic emit_init;
        logic rd_issue;
        logic out_load;
    } rde_cmd_t;

    typedef struct packed {
        logic quo_zero;
        logic cnt_full;
        logic out_free;
        logic rd_last;
    } rde_status_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d,
                                                      input logic upper);
        logic [CHAR_W-1:0] base_char;
        begin
            if (d < 4'd10) begin
                digit_ascii = CHAR_W'(8'h30) + CHAR_W'(d);
            end else begin
                base_char   = upper ? CHAR_W'(8'h41) : CHAR_W'(8'h61);
                digit_ascii = base_char + CHAR_W'(d - 4'd10);
            end
        end
    endfunction

endpackage

// ===== sv/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter
// converts one integer per transaction to ascii digits in a base of 2 to 16
// ----------------------------------------------------------------------------
// One 64-bit value (signed values by magnitude) is taken per input transaction
// and produces one output transaction per digit, most significant first, with
// last on the final digit and a saturating running character count. Digits
// come from a shared restoring divider that retires 8 dividend bits per cycle,
// so each digit is formed by the divide steps over the whole dividend and a
// check; emission reads each digit from the registered digit store and then
// loads the output register, waiting while the output register is held.
// The next value is accepted while the last digit still waits in the output
// register. radix and upper_case are written through the cfg port; the user
// must write them only while idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module radix_digit_emitter import rde_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [RADIX_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  rde_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rde_out_t           m_data
);

    rde_cmd_t    cmd;
    rde_status_t status;

    rde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rde_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/rde_ctrl.sv =====
// ----------------------------------------------------------------------------
// rde_ctrl
// controller: sequences division steps, digit checks and digit emission
// ----------------------------------------------------------------------------
module rde_ctrl import rde_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rde_status_t status,
    output rde_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_step;

    assign s_ready   = (state_reg == ST_IDLE);
    assign last_step = (step_reg == STEP_W'(DIV_CYCLES - 1));

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (last_step) begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_CHK;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_CHK: begin
                if (status.quo_zero || status.cnt_full) begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_RD;
                end else begin
                    cmd.next_digit = 1'b1;
                    step_next      = '0;
                    state_next     = ST_DIV;
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.rd_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTH
    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state_reg == ST_IDLE) && s_valid)
        else $error("load outside idle");

    a_div_then_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_last |=> (state_reg == ST_CHK))
        else $error("last division step not followed by check");

    a_rd_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> (state_reg == ST_OUT))
        else $error("read not followed by output");
`endif

endmodule

// ===== sv/rde_datapath.sv =====
// ----------------------------------------------------------------------------
// rde_datapath
// datapath: magnitude, shared radix divider, digit store and output register
// ----------------------------------------------------------------------------
module rde_datapath import rde_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [RADIX_W-1:0] cfg_wdata,
    input  rde_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rde_out_t           m_data,
    input  rde_cmd_t           cmd,
    output rde_status_t        status
);

    logic [RADIX_W-1:0]  radix_reg;
    logic                upper_reg;
    logic [RADIX_W-1:0]  base_reg, base_next;
    logic [DVD_BITS-1:0] dvd_reg, dvd_step;
    logic [4:0]          rem_reg, rem_step;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [3:0]          rd_data_reg;
    logic                rd_last_reg;
    logic [COUNT_W-1:0]  chars_reg, chars_next;
    logic                out_valid_reg;
    rde_out_t            out_reg;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]          store_mem [STORE_DEPTH];

    // magnitude and clamped base
    always_comb begin
        mag = s_data.value[VALUE_BITS-1:0];
        if (s_data.is_signed && mag[VALUE_BITS-1]) begin
            mag = ~mag + VALUE_BITS'(1);
        end
        if (radix_reg < RADIX_MIN) begin
            base_next = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base_next = RADIX_MAX;
        end else begin
            base_next = radix_reg;
        end
    end

    // one byte of restoring division per cycle
    always_comb begin
        logic [4:0]          r;
        logic [DVD_BITS-1:0] d;
        logic                q;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            r = {r[3:0], d[DVD_BITS-1]};
            q = (r >= base_reg);
            if (q) begin
                r = r - base_reg;
            end
            d = {d[DVD_BITS-2:0], q};
        end
        rem_step = r;
        dvd_step = d;
    end

    assign chars_next = (chars_reg == COUNT_MAX) ? chars_reg : chars_reg + COUNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            upper_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RADIX: radix_reg <= cfg_wdata;
                REG_UPPER: upper_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            chars_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cmd.div_last) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                chars_reg     <= chars_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dvd_reg  <= DVD_BITS'(mag);
            rem_reg  <= '0;
            base_reg <= base_next;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_step;
            rem_reg <= rem_step;
        end else if (cmd.next_digit) begin
            rem_reg <= '0;
        end
        if (cmd.emit_init) begin
            rd_idx_reg <= IDX_W'(cnt_reg - CNT_W'(1));
        end else if (cmd.out_load) begin
            rd_idx_reg <= rd_idx_reg - IDX_W'(1);
        end
        if (cmd.out_load) begin
            out_reg.digit_char    <= digit_ascii(rd_data_reg, upper_reg);
            out_reg.last          <= rd_last_reg;
            out_reg.running_count <= chars_next;
        end
    end

    // digit store
    always_ff @(posedge aclk) begin
        if (cmd.div_last) begin
            store_mem[cnt_reg[IDX_W-1:0]] <= rem_step[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[rd_idx_reg];
            rd_last_reg <= (rd_idx_reg == '0);
        end
    end

    assign status.quo_zero = (dvd_reg == '0);
    assign status.cnt_full = (cnt_reg == CNT_W'(STORE_DEPTH));
    assign status.out_free = !out_valid_reg || m_ready;
    assign status.rd_last  = rd_last_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten");

    a_digit_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_last |-> (rem_step < base_reg))
        else $error("digit not below base");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_init |-> (cnt_reg != '0))
        else $error("emission with no digits");
`endif

endmodule

// ===== tb/radix_digit_emitter_tb.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter_tb
// self-checking testbench for the radix digit emitter
// ----------------------------------------------------------------------------
// A driver feeds integer transactions from a queue and predicts the digit
// sequence of each accepted value from its own copy of radix, case and the
// running character count. A monitor compares every digit transaction with
// the oldest prediction. Directed values cover zero, the word extremes, the
// most negative signed value and out-of-range radix settings. Random phases
// then run under a series of register settings, with random idling on both
// sides and one phase without any idling.
// ----------------------------------------------------------------------------
module radix_digit_emitter_tb import rde_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_ITEMS  = 10;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = REG_RADIX;
    logic [RADIX_W-1:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    rde_in_t            s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    rde_out_t           m_data;

    rde_in_t            value_q[$];
    rde_out_t           digit_q[$];
    rde_out_t           want;
    logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
    logic               cur_upper = 1'b0;
    logic [COUNT_W-1:0] chars_emitted = '0;
    bit                 steady = 1'b0;
    int                 mismatches = 0;
    int                 stall_cycles = 0;

    radix_digit_emitter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void predict_digits(input rde_in_t item);
        logic [63:0]        mag;
        logic [4:0]         base;
        logic [3:0]         digs[64];
        logic [CHAR_W-1:0]  ch;
        rde_out_t           res;
        int                 n;
        mag = item.value;
        if (item.is_signed && mag[63]) begin
            mag = ~mag + 64'd1;
        end
        if (cur_radix < 5'd2) begin
            base = 5'd2;
        end else if (cur_radix > 5'd16) begin
            base = 5'd16;
        end else begin
            base = cur_radix;
        end
        n = 0;
        do begin
            digs[n] = 4'(mag % 64'(base));
            mag     = mag / 64'(base);
            n++;
        end while (mag != 0 && n < 64);
        for (int k = n - 1; k >= 0; k--) begin
            if (digs[k] < 4'd10) begin
                ch = 7'h30 + 7'(digs[k]);
            end else begin
                ch = (cur_upper ? 7'h41 : 7'h61) + 7'(digs[k] - 4'd10);
            end
            if (chars_emitted != COUNT_MAX) begin
                chars_emitted = chars_emitted + 1'b1;
            end
            res.digit_char    = ch;
            res.last          = (k == 0);
            res.running_count = chars_emitted;
            digit_q.push_back(res);
        end
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = ~(v >> $urandom_range(0, 63));
            2: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = '1;
                    2: v = {1'b1, 63'b0};
                    default: v = {1'b0, {63{1'b1}}};
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_value(input logic [63:0] v, input logic sgn);
        rde_in_t item;
        item.value     = v;
        item.is_signed = sgn;
        value_q.push_back(item);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (value_q.size() != 0 || s_valid || digit_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [RADIX_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic apply_setting(input logic [RADIX_W-1:0] rdx, input logic up);
        wait_drained();
        write_reg(REG_RADIX, rdx);
        write_reg(REG_UPPER, RADIX_W'(up));
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_radix  = rdx;
        cur_upper  = up;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_digits(s_data);
            end
            if (!s_valid || s_ready) begin
                if (value_q.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
                    s_valid <= 1'b1;
                    s_data  <= value_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digit_q.size() == 0) begin
                    $error("unexpected transaction: digit_char %0d", m_data.digit_char);
                    mismatches++;
                end else begin
                    want = digit_q.pop_front();
                    if (m_data.digit_char !== want.digit_char) begin
                        $error("digit_char expected %0d actual %0d",
                               want.digit_char, m_data.digit_char);
                        mismatches++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, m_data.last);
                        mismatches++;
                    end
                    if (m_data.running_count !== want.running_count) begin
                        $error("running_count expected %0d actual %0d",
                               want.running_count, m_data.running_count);
                        mismatches++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (value_q.size() == 0 && !s_valid && digit_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [RADIX_W-1:0] rdx;
        logic               up;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: decimal, lower case
        add_value(64'd0, 1'b0);
        add_value(64'd0, 1'b1);
        add_value(64'd1, 1'b0);
        add_value(64'd9, 1'b0);
        add_value(64'd10, 1'b0);
        add_value('1, 1'b0);
        add_value('1, 1'b1);
        add_value({1'b1, 63'b0}, 1'b1);
        add_value({1'b1, 63'b0}, 1'b0);
        add_value({1'b0, {63{1'b1}}}, 1'b1);
        add_value(-64'sd10, 1'b1);
        add_value({32{2'b01}}, 1'b0);
        add_value({32{2'b10}}, 1'b0);

        apply_setting(5'd16, 1'b1);
        add_value(64'hFEDC_BA98_7654_3210, 1'b0);
        add_value(64'h00AB_CDEF, 1'b1);
        add_value('1, 1'b0);

        apply_setting(5'd2, 1'b0);
        add_value('1, 1'b0);
        add_value({1'b1, 63'b0}, 1'b1);

        // radix outside two to sixteen
        apply_setting(5'd0, 1'b1);
        add_value(64'd5, 1'b0);
        apply_setting(5'd31, 1'b0);
        add_value(64'hFACE, 1'b0);
        apply_setting(5'd1, 1'b1);
        add_value(64'd6, 1'b1);
        apply_setting(5'd17, 1'b1);
        add_value(64'hBEEF, 1'b0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: rdx = 5'd2;
                1: rdx = 5'd16;
                2: rdx = 5'd10;
                3: rdx = 5'd0;
                4: rdx = 5'd31;
                default: rdx = RADIX_W'($urandom_range(0, 31));
            endcase
            up = (p < 5) ? p[0] : 1'($urandom);
            apply_setting(rdx, up);
            steady = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                add_value(rand_value(), 1'($urandom));
            end
        end

        wait_drained();
        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rde_pkg.sv
sv/rde_ctrl.sv
sv/rde_datapath.sv
sv/radix_digit_emitter.sv
tb/radix_digit_emitter_tb.sv
